[rtl/stok_pkg.sv]
// shared types, codes and defaults for the source tokenizer
package stok_pkg;

	// default configuration of the lexer
	localparam int CELL_BITS_DEF         = 16;
	localparam int MAX_TOKEN_LEN_DEF     = 64;
	localparam int MAX_COMMENT_DEPTH_DEF = 255;

	// entries in the queue between front and back
	localparam int QUEUE_DEPTH = 4;

	// character codes the lexer reacts to
	localparam logic [7:0] CH_SEMI    = 8'h3B;
	localparam logic [7:0] CH_LPAREN  = 8'h28;
	localparam logic [7:0] CH_RPAREN  = 8'h29;
	localparam logic [7:0] CH_AT      = 8'h40;
	localparam logic [7:0] CH_DQUOTE  = 8'h22;
	localparam logic [7:0] CH_SQUOTE  = 8'h27;
	localparam logic [7:0] CH_COLON   = 8'h3A;
	localparam logic [7:0] CH_NL      = 8'h0A;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_TAB     = 8'h09;
	localparam logic [7:0] CH_CR      = 8'h0D;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_NINE    = 8'h39;
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_LOWER_F = 8'h66;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_F = 8'h46;
	localparam logic [7:0] CH_LOWER_X = 8'h78;
	localparam logic [7:0] CH_UPPER_X = 8'h58;

	typedef enum logic [3:0] {
		MODE_IDLE,
		MODE_LINECMT,
		MODE_BLOCKCMT,
		MODE_QSTRING,
		MODE_CSTRING,
		MODE_ADDRESS,
		MODE_WORD,
		MODE_NUMBER,
		MODE_SKIP
	} mode_t;

	typedef enum logic [1:0] {
		RADIX_DEC,
		RADIX_OCT,
		RADIX_HEX
	} radix_t;

	typedef enum logic [1:0] {
		PH_START,
		PH_ZERO,
		PH_HEXPFX,
		PH_DIGITS
	} phase_t;

	typedef enum logic [3:0] {
		EV_WORD_CHAR,
		EV_ADDR_CHAR,
		EV_STR_CHAR,
		EV_WORD_END,
		EV_ADDR_END,
		EV_STR_END,
		EV_NUMBER,
		EV_LINE_END,
		EV_INPUT_END,
		EV_ERROR
	} ev_t;

	typedef enum logic [1:0] {
		ERR_BAD_NUMBER,
		ERR_TOO_LONG,
		ERR_OPEN_AT_END
	} err_t;

	// one result of the lexer
	typedef struct packed {
		ev_t         ev;
		logic [7:0]  ch;
		logic [15:0] num;
		err_t        ek;
	} result_t;

	// everything one character caused: one or two results
	typedef struct packed {
		logic    two;
		result_t r0;
		result_t r1;
	} entry_t;

endpackage

[rtl/stok_char_if.sv]
// character channel into the tokenizer
interface stok_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_in;
	logic       end_of_input;

	modport source (output valid, output char_in, output end_of_input, input ready);
	modport sink (input valid, input char_in, input end_of_input, output ready);
endinterface

[rtl/stok_event_if.sv]
// token event channel out of the tokenizer
interface stok_event_if;
	logic        valid;
	logic        ready;
	logic [3:0]  event_res;
	logic [7:0]  char_out;
	logic [15:0] number_value;
	logic [1:0]  error_kind;
	logic        last;

	modport source (output valid, output event_res, output char_out, output number_value,
		output error_kind, output last, input ready);
	modport sink (input valid, input event_res, input char_out, input number_value,
		input error_kind, input last, output ready);
endinterface

[rtl/stok_front.sv]
// lexer front: accepts characters, keeps the lexer state, forms the results of each one
module stok_front #(
	parameter int CELL_BITS         = stok_pkg::CELL_BITS_DEF,
	parameter int MAX_TOKEN_LEN     = stok_pkg::MAX_TOKEN_LEN_DEF,
	parameter int MAX_COMMENT_DEPTH = stok_pkg::MAX_COMMENT_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	stok_char_if.sink         char_stream,
	input  logic              full,
	output logic              push,
	output stok_pkg::entry_t  entry
);
	import stok_pkg::*;

	localparam int LEN_W   = $clog2(MAX_TOKEN_LEN + 1);
	localparam int DEPTH_W = $clog2(MAX_COMMENT_DEPTH + 1);
	localparam int PROD_W  = CELL_BITS + 5;

	function automatic logic is_ws(input logic [7:0] c);
		return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
	endfunction

	// digit value in any radix, 16 for a non-digit
	function automatic logic [4:0] digit_value(input logic [7:0] c);
		logic [7:0] v;
		v = 8'd16;
		if ((c >= CH_ZERO) && (c <= CH_NINE)) v = c - CH_ZERO;
		else if ((c >= CH_LOWER_A) && (c <= CH_LOWER_F)) v = c - CH_LOWER_A + 8'd10;
		else if ((c >= CH_UPPER_A) && (c <= CH_UPPER_F)) v = c - CH_UPPER_A + 8'd10;
		return v[4:0];
	endfunction

	function automatic result_t mk_res(input ev_t ev, input logic [7:0] ch,
		input logic [15:0] num, input err_t ek);
		result_t r;
		r.ev  = ev;
		r.ch  = ch;
		r.num = num;
		r.ek  = ek;
		return r;
	endfunction

	// lexer state
	mode_t                mode_q, mode_d;
	logic [DEPTH_W-1:0]   depth_q, depth_d;
	logic [7:0]           quote_q, quote_d;
	logic [CELL_BITS-1:0] acc_q, acc_d;
	radix_t               radix_q, radix_d;
	phase_t               phase_q, phase_d;
	logic                 bad_q, bad_d;
	logic [LEN_W-1:0]     len_q, len_d;

	logic [7:0] c;
	logic       accept;
	logic       ws;
	logic       at_max_len;
	logic       num_ok;
	logic [15:0] num_out;
	logic [CELL_BITS+15:0] acc_ext;

	// idle handling of the current character
	mode_t                id_mode;
	logic [DEPTH_W-1:0]   id_depth;
	logic [7:0]           id_quote;
	logic [CELL_BITS-1:0] id_acc;
	radix_t               id_radix;
	phase_t               id_phase;
	logic                 id_bad;
	logic [LEN_W-1:0]     id_len;
	logic                 id_valid;
	result_t              id_res;

	// number digit step
	logic [4:0]           dig;
	logic [4:0]           rad_val;
	logic [PROD_W-1:0]    acc_x;
	logic [PROD_W-1:0]    prod;
	logic                 fd_bad;
	radix_t               fd_radix;
	phase_t               fd_phase;
	logic [CELL_BITS-1:0] fd_acc;

	// result slots: a comes before b
	logic    va, vb;
	result_t ra, rb;

	assign c          = char_stream.char_in;
	assign char_stream.ready = !full;
	assign accept     = char_stream.valid && !full;
	assign ws         = is_ws(c);
	assign at_max_len = len_q >= LEN_W'(MAX_TOKEN_LEN);
	assign num_ok     = !bad_q && (phase_q != PH_START) && (phase_q != PH_HEXPFX);
	assign acc_ext    = {16'b0, acc_q};
	assign num_out    = acc_ext[15:0];

	// character seen between tokens
	always_comb begin
		id_mode  = MODE_IDLE;
		id_depth = '0;
		id_quote = quote_q;
		id_acc   = acc_q;
		id_radix = radix_q;
		id_phase = phase_q;
		id_bad   = bad_q;
		id_len   = '0;
		id_valid = 1'b0;
		id_res   = mk_res(EV_LINE_END, 8'd0, 16'd0, ERR_BAD_NUMBER);
		if (c == CH_NL) begin
			id_valid = 1'b1;
		end else if (!ws) begin
			case (c)
				CH_SEMI: id_mode = MODE_LINECMT;
				CH_LPAREN: begin
					id_mode  = MODE_BLOCKCMT;
					id_depth = DEPTH_W'(1);
				end
				CH_AT: id_mode = MODE_ADDRESS;
				CH_DQUOTE, CH_SQUOTE: begin
					id_mode  = MODE_QSTRING;
					id_quote = c;
				end
				CH_COLON: id_mode = MODE_CSTRING;
				default: begin
					id_len = LEN_W'(1);
					if ((c >= CH_ZERO) && (c <= CH_NINE)) begin
						id_mode  = MODE_NUMBER;
						id_acc   = CELL_BITS'(c - CH_ZERO);
						id_radix = (c == CH_ZERO) ? RADIX_OCT : RADIX_DEC;
						id_phase = (c == CH_ZERO) ? PH_ZERO : PH_DIGITS;
						id_bad   = 1'b0;
					end else begin
						id_mode  = MODE_WORD;
						id_valid = 1'b1;
						id_res   = mk_res(EV_WORD_CHAR, c, 16'd0, ERR_BAD_NUMBER);
					end
				end
			endcase
		end
	end

	// one digit into the number accumulator
	always_comb begin
		dig   = digit_value(c);
		acc_x = {5'b0, acc_q};
		case (radix_q)
			RADIX_OCT: begin
				rad_val = 5'd8;
				prod    = (acc_x << 3) + PROD_W'(dig);
			end
			RADIX_HEX: begin
				rad_val = 5'd16;
				prod    = (acc_x << 4) + PROD_W'(dig);
			end
			default: begin
				rad_val = 5'd10;
				prod    = (acc_x << 3) + (acc_x << 1) + PROD_W'(dig);
			end
		endcase
		fd_bad   = bad_q;
		fd_radix = radix_q;
		fd_phase = phase_q;
		fd_acc   = acc_q;
		if (!bad_q) begin
			if ((phase_q == PH_ZERO) && ((c == CH_LOWER_X) || (c == CH_UPPER_X))) begin
				fd_radix = RADIX_HEX;
				fd_phase = PH_HEXPFX;
			end else if ((dig >= rad_val) || (prod[PROD_W-1:CELL_BITS] != '0)) begin
				fd_bad = 1'b1;
			end else begin
				fd_acc   = prod[CELL_BITS-1:0];
				fd_phase = ((phase_q == PH_START) && (c == CH_ZERO)) ? PH_ZERO : PH_DIGITS;
			end
		end
	end

	// next lexer state and results
	always_comb begin
		mode_d  = mode_q;
		depth_d = depth_q;
		quote_d = quote_q;
		acc_d   = acc_q;
		radix_d = radix_q;
		phase_d = phase_q;
		bad_d   = bad_q;
		len_d   = len_q;
		va      = 1'b0;
		vb      = 1'b0;
		ra      = mk_res(EV_ERROR, 8'd0, 16'd0, ERR_BAD_NUMBER);
		rb      = mk_res(EV_INPUT_END, 8'd0, 16'd0, ERR_BAD_NUMBER);
		if (char_stream.end_of_input) begin
			// close whatever is open, then report input end
			case (mode_q)
				MODE_BLOCKCMT, MODE_QSTRING, MODE_CSTRING: begin
					va = 1'b1;
					ra = mk_res(EV_ERROR, 8'd0, 16'd0, ERR_OPEN_AT_END);
				end
				MODE_WORD: begin
					va = 1'b1;
					ra = mk_res(EV_WORD_END, 8'd0, 16'd0, ERR_BAD_NUMBER);
				end
				MODE_ADDRESS: begin
					va = 1'b1;
					ra = mk_res(EV_ADDR_END, 8'd0, 16'd0, ERR_BAD_NUMBER);
				end
				MODE_NUMBER: begin
					va = 1'b1;
					if (num_ok) ra = mk_res(EV_NUMBER, 8'd0, num_out, ERR_BAD_NUMBER);
				end
				default: va = 1'b0;
			endcase
			vb      = 1'b1;
			mode_d  = MODE_IDLE;
			depth_d = '0;
			len_d   = '0;
		end else begin
			case (mode_q)
				MODE_LINECMT: begin
					if (c == CH_NL) begin
						mode_d = MODE_IDLE;
						len_d  = '0;
						va     = 1'b1;
						ra     = mk_res(EV_LINE_END, 8'd0, 16'd0, ERR_BAD_NUMBER);
					end
				end
				MODE_BLOCKCMT: begin
					if (c == CH_LPAREN) begin
						if (depth_q < DEPTH_W'(MAX_COMMENT_DEPTH)) depth_d = depth_q + 1'b1;
					end else if (c == CH_RPAREN) begin
						if (depth_q <= DEPTH_W'(1)) begin
							mode_d  = MODE_IDLE;
							depth_d = '0;
							len_d   = '0;
						end else begin
							depth_d = depth_q - 1'b1;
						end
					end
				end
				MODE_QSTRING: begin
					va = 1'b1;
					if (c == quote_q) begin
						mode_d = MODE_IDLE;
						len_d  = '0;
						ra     = mk_res(EV_STR_END, 8'd0, 16'd0, ERR_BAD_NUMBER);
					end else if (at_max_len) begin
						mode_d = MODE_SKIP;
						len_d  = '0;
						ra     = mk_res(EV_ERROR, 8'd0, 16'd0, ERR_TOO_LONG);
					end else begin
						len_d = len_q + 1'b1;
						ra    = mk_res(EV_STR_CHAR, c, 16'd0, ERR_BAD_NUMBER);
					end
				end
				MODE_CSTRING, MODE_ADDRESS, MODE_WORD: begin
					va = 1'b1;
					if (ws) begin
						case (mode_q)
							MODE_CSTRING: ra = mk_res(EV_STR_END, 8'd0, 16'd0, ERR_BAD_NUMBER);
							MODE_ADDRESS: ra = mk_res(EV_ADDR_END, 8'd0, 16'd0, ERR_BAD_NUMBER);
							default:      ra = mk_res(EV_WORD_END, 8'd0, 16'd0, ERR_BAD_NUMBER);
						endcase
						mode_d  = id_mode;
						depth_d = id_depth;
						len_d   = id_len;
						vb      = id_valid;
						rb      = id_res;
					end else if (at_max_len) begin
						mode_d = MODE_SKIP;
						len_d  = '0;
						ra     = mk_res(EV_ERROR, 8'd0, 16'd0, ERR_TOO_LONG);
					end else begin
						len_d = len_q + 1'b1;
						case (mode_q)
							MODE_CSTRING: ra = mk_res(EV_STR_CHAR, c, 16'd0, ERR_BAD_NUMBER);
							MODE_ADDRESS: ra = mk_res(EV_ADDR_CHAR, c, 16'd0, ERR_BAD_NUMBER);
							default:      ra = mk_res(EV_WORD_CHAR, c, 16'd0, ERR_BAD_NUMBER);
						endcase
					end
				end
				MODE_NUMBER: begin
					if (ws) begin
						va    = 1'b1;
						len_d = '0;
						if (num_ok) begin
							ra      = mk_res(EV_NUMBER, 8'd0, num_out, ERR_BAD_NUMBER);
							mode_d  = id_mode;
							depth_d = id_depth;
							vb      = id_valid;
							rb      = id_res;
						end else begin
							// a newline ending a bad number also ends the discard
							mode_d = (c == CH_NL) ? MODE_IDLE : MODE_SKIP;
						end
					end else if (at_max_len) begin
						va     = 1'b1;
						mode_d = MODE_SKIP;
						len_d  = '0;
						ra     = mk_res(EV_ERROR, 8'd0, 16'd0, ERR_TOO_LONG);
					end else begin
						len_d   = len_q + 1'b1;
						acc_d   = fd_acc;
						radix_d = fd_radix;
						phase_d = fd_phase;
						bad_d   = fd_bad;
					end
				end
				MODE_SKIP: begin
					if (c == CH_NL) begin
						mode_d = MODE_IDLE;
						len_d  = '0;
					end
				end
				default: begin
					mode_d  = id_mode;
					depth_d = id_depth;
					quote_d = id_quote;
					acc_d   = id_acc;
					radix_d = id_radix;
					phase_d = id_phase;
					bad_d   = id_bad;
					len_d   = id_len;
					vb      = id_valid;
					rb      = id_res;
				end
			endcase
		end
	end

	// pack the used slots into one queue entry
	always_comb begin
		push = accept && (va || vb);
		if (va) begin
			entry.r0  = ra;
			entry.r1  = rb;
			entry.two = vb;
		end else begin
			entry.r0  = rb;
			entry.r1  = rb;
			entry.two = 1'b0;
		end
	end

	// state update on each accepted transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_IDLE;
			depth_q <= '0;
			quote_q <= '0;
			acc_q   <= '0;
			radix_q <= RADIX_DEC;
			phase_q <= PH_START;
			bad_q   <= 1'b0;
			len_q   <= '0;
		end else if (accept) begin
			mode_q  <= mode_d;
			depth_q <= depth_d;
			quote_q <= quote_d;
			acc_q   <= acc_d;
			radix_q <= radix_d;
			phase_q <= phase_d;
			bad_q   <= bad_d;
			len_q   <= len_d;
		end
	end

endmodule

[rtl/stok_queue.sv]
// short queue of result entries between lexer front and back
module stok_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  stok_pkg::entry_t wr_entry,
	output logic             full,
	input  logic             pop,
	output logic             empty,
	output stok_pkg::entry_t rd_entry
);
	import stok_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	entry_t             slots_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_push;
	logic               do_pop;

	assign full     = count_q == CNT_W'(QUEUE_DEPTH);
	assign empty    = count_q == '0;
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign rd_entry = slots_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) slots_q[wr_ptr_q] <= wr_entry;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) count_q <= count_q + 1'b1;
			else if (do_pop && !do_push) count_q <= count_q - 1'b1;
		end
	end

endmodule

[rtl/stok_back.sv]
// lexer back: splits queue entries into single events and drives the output register
module stok_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             empty,
	input  stok_pkg::entry_t head,
	output logic             pop,
	stok_event_if.source     event_stream
);
	import stok_pkg::*;

	logic    out_valid_q, out_valid_d;
	result_t out_res_q, out_res_d;
	logic    out_last_q, out_last_d;
	logic    second_q, second_d;
	logic    load;

	assign load = !out_valid_q || event_stream.ready;

	// choose the next event from the head entry
	always_comb begin
		pop         = 1'b0;
		second_d    = second_q;
		out_valid_d = out_valid_q;
		out_res_d   = out_res_q;
		out_last_d  = out_last_q;
		if (load) begin
			out_valid_d = !empty;
			if (!empty) begin
				if (!second_q) begin
					out_res_d  = head.r0;
					out_last_d = !head.two;
					second_d   = head.two;
					pop        = !head.two;
				end else begin
					out_res_d  = head.r1;
					out_last_d = 1'b1;
					second_d   = 1'b0;
					pop        = 1'b1;
				end
			end
		end
	end

	// output control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			second_q    <= 1'b0;
		end else begin
			out_valid_q <= out_valid_d;
			second_q    <= second_d;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		out_res_q  <= out_res_d;
		out_last_q <= out_last_d;
	end

	assign event_stream.valid        = out_valid_q;
	assign event_stream.event_res    = out_res_q.ev;
	assign event_stream.char_out     = out_res_q.ch;
	assign event_stream.number_value = out_res_q.num;
	assign event_stream.error_kind   = out_res_q.ek;
	assign event_stream.last         = out_last_q;

endmodule

[rtl/source_tokenizer.sv]
// top level of the source tokenizer
// The tokenizer takes one character transaction per cycle and turns it into zero, one or
// two event transactions (word, address and string characters, token ends, numbers, line
// end, input end, errors); the last event of each character carries last. The front holds
// the lexer state and updates it once per character, so characters go in back to back
// while the queue has room. The back emits one event per cycle while the sink is ready,
// from a four-entry queue; a two-event character stays at the queue head until its second
// event is loaded. Every event passes a queue slot and the output register. Numbers are
// parsed in CELL_BITS wide arithmetic and reported as their low 16 bits; tokens hold at
// most MAX_TOKEN_LEN characters and comment nesting saturates at MAX_COMMENT_DEPTH.
module source_tokenizer #(
	parameter int CELL_BITS         = stok_pkg::CELL_BITS_DEF,
	parameter int MAX_TOKEN_LEN     = stok_pkg::MAX_TOKEN_LEN_DEF,
	parameter int MAX_COMMENT_DEPTH = stok_pkg::MAX_COMMENT_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	stok_char_if.sink     char_stream,
	stok_event_if.source  event_stream
);
	import stok_pkg::*;

	logic   push;
	logic   full;
	logic   pop;
	logic   empty;
	entry_t wr_entry;
	entry_t rd_entry;

	// character classification and lexer state
	stok_front #(
		.CELL_BITS         (CELL_BITS),
		.MAX_TOKEN_LEN     (MAX_TOKEN_LEN),
		.MAX_COMMENT_DEPTH (MAX_COMMENT_DEPTH)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.char_stream (char_stream),
		.full        (full),
		.push        (push),
		.entry       (wr_entry)
	);

	// decoupling queue
	stok_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_entry (wr_entry),
		.full     (full),
		.pop      (pop),
		.empty    (empty),
		.rd_entry (rd_entry)
	);

	// event output
	stok_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.empty        (empty),
		.head         (rd_entry),
		.pop          (pop),
		.event_stream (event_stream)
	);

endmodule
